>>> sv/dff_pkg.sv
package dff_pkg;

   localparam int MAX_DIGITS    = 10;
   localparam int CHAR_ADVANCE  = 8;
   localparam int NUM_WIDTH     = 32;
   localparam int BCD_DIGITS    = 10;
   localparam int BCD_BITS      = 4 * BCD_DIGITS;
   localparam int BITS_PER_STEP = 4;
   localparam int CONV_STEPS    = NUM_WIDTH / BITS_PER_STEP;
   localparam int STEP_WIDTH    = $clog2(CONV_STEPS);
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_WIDTH    = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] FONT_HEIGHT_OK = 8'd16;
   localparam logic [5:0] CODE_BLANK     = 6'd32;
   localparam logic [5:0] CODE_ZERO      = 6'd48;

   typedef struct packed {
      logic [NUM_WIDTH-1:0] number_value;
      logic [3:0]           digit_places;
      logic [9:0]           start_x;
      logic [9:0]           start_y;
      logic [15:0]          ink_color;
   } queue_entry_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_CONVERT,
      BACK_EMIT
   } back_state_type;

endpackage

>>> sv/dff_front.sv
module dff_front
   import dff_pkg::*;
(
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [31:0]          req_number_value,
   input  logic [3:0]           req_digit_places,
   input  logic [7:0]           req_font_height,
   input  logic [9:0]           req_start_x,
   input  logic [9:0]           req_start_y,
   input  logic [15:0]          req_ink_color,
   input  logic                 queue_full,
   output logic                 queue_push,
   output queue_entry_type      queue_data
);

   logic [3:0] places_clamped;
   logic       item_kept;

   always_comb begin
      if (req_digit_places > 4'(MAX_DIGITS)) begin
         places_clamped = 4'(MAX_DIGITS);
      end else begin
         places_clamped = req_digit_places;
      end
      item_kept = (req_font_height == FONT_HEIGHT_OK) && (places_clamped != 4'd0);
   end

   // items that print nothing are accepted and dropped here
   assign req_stall  = queue_full;
   assign queue_push = req_valid && !queue_full && item_kept;

   assign queue_data.number_value = req_number_value;
   assign queue_data.digit_places = places_clamped;
   assign queue_data.start_x      = req_start_x;
   assign queue_data.start_y      = req_start_y;
   assign queue_data.ink_color    = req_ink_color;

endmodule

>>> sv/dff_queue.sv
module dff_queue
   import dff_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  queue_entry_type push_data,
   output logic            full,
   input  logic            pop,
   output queue_entry_type pop_data,
   output logic            not_empty
);

   queue_entry_type        entry_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0]  count_ff, count_in;

   assign full      = (count_ff == QCNT_WIDTH'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("queue push while full");
   assert property (@(posedge clock) disable iff (reset) !(pop && !not_empty))
      else $error("queue pop while empty");

endmodule

>>> sv/dff_back.sv
module dff_back
   import dff_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            queue_not_empty,
   input  queue_entry_type queue_data,
   output logic            queue_pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [10:0]     rsp_char_x,
   output logic [9:0]      rsp_char_y,
   output logic [5:0]      rsp_char_code,
   output logic [15:0]     rsp_char_color,
   output logic            rsp_last_char
);

   back_state_type state_ff, state_in;

   logic [BCD_DIGITS-1:0][3:0] bcd_ff, bcd_in;
   logic [NUM_WIDTH-1:0]       bin_ff, bin_in;
   logic [STEP_WIDTH-1:0]      step_ff, step_in;
   logic [3:0]                 idx_ff, idx_in;
   logic                       shown_ff, shown_in;
   logic [10:0]                x_ff, x_in;
   logic [9:0]                 y_ff, y_in;
   logic [15:0]                color_ff, color_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [10:0] rsp_x_ff, rsp_x_in;
   logic [9:0]  rsp_y_ff, rsp_y_in;
   logic [5:0]  rsp_code_ff, rsp_code_in;
   logic [15:0] rsp_color_ff, rsp_color_in;
   logic        rsp_last_ff, rsp_last_in;

   logic [BCD_DIGITS-1:0][3:0] conv_bcd;
   logic [NUM_WIDTH-1:0]       conv_bin;
   logic                       out_free;
   logic                       emit_load;
   logic [3:0]                 cur_digit;
   logic                       blank;

   // double dabble, four bits per cycle
   always_comb begin
      conv_bcd = bcd_ff;
      conv_bin = bin_ff;
      for (int s = 0; s < BITS_PER_STEP; s++) begin
         for (int d = 0; d < BCD_DIGITS; d++) begin
            if (conv_bcd[d] >= 4'd5) begin
               conv_bcd[d] = conv_bcd[d] + 4'd3;
            end
         end
         conv_bcd = BCD_BITS'({conv_bcd, conv_bin[NUM_WIDTH-1]});
         conv_bin = {conv_bin[NUM_WIDTH-2:0], 1'b0};
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign cur_digit = bcd_ff[idx_ff];
   assign blank     = !shown_ff && (idx_ff != 4'd0) && (cur_digit == 4'd0);
   assign emit_load = (state_ff == BACK_EMIT) && out_free;

   always_comb begin
      state_in     = state_ff;
      bcd_in       = bcd_ff;
      bin_in       = bin_ff;
      step_in      = step_ff;
      idx_in       = idx_ff;
      shown_in     = shown_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      color_in     = color_ff;
      queue_pop    = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_color_in = rsp_color_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (queue_not_empty) begin
               queue_pop = 1'b1;
               bcd_in    = '0;
               bin_in    = queue_data.number_value;
               step_in   = '0;
               idx_in    = queue_data.digit_places - 4'd1;
               shown_in  = 1'b0;
               x_in      = {1'b0, queue_data.start_x};
               y_in      = queue_data.start_y;
               color_in  = queue_data.ink_color;
               state_in  = BACK_CONVERT;
            end
         end
         BACK_CONVERT: begin
            bcd_in  = conv_bcd;
            bin_in  = conv_bin;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_WIDTH'(CONV_STEPS - 1)) begin
               state_in = BACK_EMIT;
            end
         end
         BACK_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = x_ff;
               rsp_y_in     = y_ff;
               rsp_code_in  = blank ? CODE_BLANK : CODE_ZERO + {2'b00, cur_digit};
               rsp_color_in = color_ff;
               rsp_last_in  = (idx_ff == 4'd0);
               shown_in     = shown_ff || !blank;
               x_in         = x_ff + 11'(CHAR_ADVANCE);
               idx_in       = idx_ff - 4'd1;
               if (idx_ff == 4'd0) begin
                  state_in = BACK_IDLE;
               end
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bcd_ff       <= bcd_in;
      bin_ff       <= bin_in;
      step_ff      <= step_in;
      idx_ff       <= idx_in;
      shown_ff     <= shown_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      color_ff     <= color_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_color_ff <= rsp_color_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_char_x     = rsp_x_ff;
   assign rsp_char_y     = rsp_y_ff;
   assign rsp_char_code  = rsp_code_ff;
   assign rsp_char_color = rsp_color_ff;
   assign rsp_last_char  = rsp_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      queue_pop |-> (state_ff == BACK_IDLE) && queue_not_empty)
      else $error("pop outside idle");
   assert property (@(posedge clock) disable iff (reset)
      (emit_load && idx_ff == 4'd0) |=> (state_ff == BACK_IDLE) && rsp_last_char)
      else $error("last character not marked");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == BACK_EMIT) |-> (idx_ff < 4'(MAX_DIGITS)) && (cur_digit <= 4'd9))
      else $error("digit index or value out of range");

endmodule

>>> sv/decimal_field_formatter.sv
// Prints an unsigned 32-bit number as a field of 1 to 10 decimal characters,
// most significant place first, leading zeros blanked, last place always a
// digit, one rsp item per place with x stepping by 8 and a mark on the last.
// Items with a font height other than 16 or a width of 0 are accepted and
// give nothing; widths above 10 act as 10. A two-entry queue separates
// intake from the back end, which converts one number at a time:
// binary-to-BCD conversion (4 bits per cycle), then the places in order,
// holding while rsp is stalled, then back to idle to fetch the next item.
module decimal_field_formatter
   import dff_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_number_value,
   input  logic [3:0]  req_digit_places,
   input  logic [7:0]  req_font_height,
   input  logic [9:0]  req_start_x,
   input  logic [9:0]  req_start_y,
   input  logic [15:0] req_ink_color,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [10:0] rsp_char_x,
   output logic [9:0]  rsp_char_y,
   output logic [5:0]  rsp_char_code,
   output logic [15:0] rsp_char_color,
   output logic        rsp_last_char
);

   logic            queue_full;
   logic            queue_push;
   logic            queue_pop;
   logic            queue_not_empty;
   queue_entry_type push_data;
   queue_entry_type pop_data;

   dff_front u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_number_value (req_number_value),
      .req_digit_places (req_digit_places),
      .req_font_height  (req_font_height),
      .req_start_x      (req_start_x),
      .req_start_y      (req_start_y),
      .req_ink_color    (req_ink_color),
      .queue_full       (queue_full),
      .queue_push       (queue_push),
      .queue_data       (push_data)
   );

   dff_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_data  (pop_data),
      .not_empty (queue_not_empty)
   );

   dff_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_not_empty (queue_not_empty),
      .queue_data      (pop_data),
      .queue_pop       (queue_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_char_x      (rsp_char_x),
      .rsp_char_y      (rsp_char_y),
      .rsp_char_code   (rsp_char_code),
      .rsp_char_color  (rsp_char_color),
      .rsp_last_char   (rsp_last_char)
   );

endmodule

>>> tb/tb.sv
module tb;
   import dff_pkg::*;

   typedef struct {
      logic [10:0] x;
      logic [9:0]  y;
      logic [5:0]  code;
      logic [15:0] color;
      logic        last;
   } char_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_number_value = '0;
   logic [3:0]  req_digit_places = '0;
   logic [7:0]  req_font_height = '0;
   logic [9:0]  req_start_x = '0;
   logic [9:0]  req_start_y = '0;
   logic [15:0] req_ink_color = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [10:0] rsp_char_x;
   logic [9:0]  rsp_char_y;
   logic [5:0]  rsp_char_code;
   logic [15:0] rsp_char_color;
   logic        rsp_last_char;

   char_type expected_chars[$];
   char_type want;
   int       mismatch_count = 0;
   bit       calm = 1'b0;
   bit       hold_request = 1'b0;
   int       hold_left = 0;

   decimal_field_formatter DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_number_value(req_number_value),
      .req_digit_places(req_digit_places),
      .req_font_height(req_font_height),
      .req_start_x    (req_start_x),
      .req_start_y    (req_start_y),
      .req_ink_color  (req_ink_color),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_char_x     (rsp_char_x),
      .rsp_char_y     (rsp_char_y),
      .rsp_char_code  (rsp_char_code),
      .rsp_char_color (rsp_char_color),
      .rsp_last_char  (rsp_last_char)
   );

   always #1 clock = ~clock;

   // expected characters of one number
   task automatic predict_field(input logic [31:0] num, input logic [3:0] places,
                                input logic [7:0] font, input logic [9:0] sx,
                                input logic [9:0] sy, input logic [15:0] color);
      int n;
      int t;
      longint unsigned weight;
      int digit;
      bit shown;
      char_type c;
      n = places;
      if (n > MAX_DIGITS) n = MAX_DIGITS;
      if (font != FONT_HEIGHT_OK || n == 0) return;
      shown = 1'b0;
      for (t = 0; t < n; t++) begin
         weight = 1;
         repeat (n - t - 1) weight *= 10;
         digit = int'((longint'(num) / weight) % 10);
         if (!shown && (t + 1 < n) && digit == 0) begin
            c.code = CODE_BLANK;
         end else begin
            shown = 1'b1;
            c.code = CODE_ZERO + 6'(digit);
         end
         c.x = 11'(sx + CHAR_ADVANCE * t);
         c.y = sy;
         c.color = color;
         c.last = (t + 1 == n);
         expected_chars.push_back(c);
      end
   endtask

   task automatic send_item(input logic [31:0] num, input logic [3:0] places,
                            input logic [7:0] font, input logic [9:0] sx,
                            input logic [9:0] sy, input logic [15:0] color);
      int gap;
      if (!calm && $urandom_range(99) < 20) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_number_value <= num;
      req_digit_places <= places;
      req_font_height <= font;
      req_start_x <= sx;
      req_start_y <= sy;
      req_ink_color <= color;
      do @(posedge clock); while (req_stall);
      predict_field(num, places, font, sx, sy, color);
   endtask

   task automatic check_field(input string name, input int exp_val, input int act_val);
      if (exp_val != act_val) begin
         $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_chars.size() == 0) begin
            $error("char_code mismatch: expected none, actual %0d", rsp_char_code);
            mismatch_count++;
         end else begin
            want = expected_chars.pop_front();
            check_field("char_x", want.x, rsp_char_x);
            check_field("char_y", want.y, rsp_char_y);
            check_field("char_code", want.code, rsp_char_code);
            check_field("char_color", want.color, rsp_char_color);
            check_field("last_char", want.last, rsp_last_char);
         end
      end
   end

   // receiver: random stall, or a long hold-off on request
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (calm) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < 20);
      end
   end

   task automatic test_extremes();
      send_item(32'd0, 4'd1, FONT_HEIGHT_OK, 10'd0, 10'd0, 16'h0000);
      send_item(32'hFFFF_FFFF, 4'd10, FONT_HEIGHT_OK, 10'd1023, 10'd1023, 16'hFFFF);
      send_item(32'hFFFF_FFFF, 4'd9, FONT_HEIGHT_OK, 10'd512, 10'd1, 16'hA5A5);
      send_item(32'd4000000000, 4'd10, FONT_HEIGHT_OK, 10'd1016, 10'd700, 16'h5A5A);
      send_item(32'd1000000000, 4'd10, FONT_HEIGHT_OK, 10'd3, 10'd5, 16'h8001);
      send_item(32'd7, 4'd11, FONT_HEIGHT_OK, 10'd100, 10'd200, 16'h1234);
      send_item(32'hFFFF_FFFF, 4'd15, FONT_HEIGHT_OK, 10'd1023, 10'd0, 16'hFFFF);
   endtask

   task automatic test_blanking();
      send_item(32'd0, 4'd10, FONT_HEIGHT_OK, 10'd40, 10'd60, 16'h07E0);
      send_item(32'd0, 4'd4, FONT_HEIGHT_OK, 10'd8, 10'd16, 16'hF800);
      send_item(32'd123, 4'd5, FONT_HEIGHT_OK, 10'd0, 10'd30, 16'h001F);
      send_item(32'd100, 4'd3, FONT_HEIGHT_OK, 10'd9, 10'd9, 16'hFFE0);
      send_item(32'd5, 4'd1, FONT_HEIGHT_OK, 10'd1023, 10'd1023, 16'h0001);
      send_item(32'd1234567, 4'd3, FONT_HEIGHT_OK, 10'd77, 10'd88, 16'hBEEF);
      send_item(32'd1000, 4'd3, FONT_HEIGHT_OK, 10'd20, 10'd20, 16'hCAFE);
      send_item(32'd90000, 4'd6, FONT_HEIGHT_OK, 10'd300, 10'd400, 16'h0F0F);
   endtask

   task automatic test_no_output();
      send_item(32'd12345, 4'd0, FONT_HEIGHT_OK, 10'd1, 10'd2, 16'h1111);
      send_item(32'd12345, 4'd5, 8'd0, 10'd1, 10'd2, 16'h2222);
      send_item(32'd12345, 4'd5, 8'd15, 10'd1, 10'd2, 16'h3333);
      send_item(32'd12345, 4'd5, 8'd17, 10'd1, 10'd2, 16'h4444);
      send_item(32'd12345, 4'd5, 8'd255, 10'd1, 10'd2, 16'h5555);
      send_item(32'd12345, 4'd5, FONT_HEIGHT_OK, 10'd1, 10'd2, 16'h6666);
   endtask

   task automatic test_backpressure();
      int i;
      calm = 1'b1;
      hold_request = 1'b1;
      for (i = 0; i < 8; i++)
         send_item($urandom, 4'd10, FONT_HEIGHT_OK, 10'($urandom), 10'($urandom),
                   16'($urandom));
      calm = 1'b0;
   endtask

   task automatic test_random();
      int i;
      logic [31:0] num;
      logic [31:0] p;
      logic [3:0]  places;
      logic [7:0]  font;
      for (i = 0; i < 320; i++) begin
         calm = (i >= 120 && i < 180);
         case ($urandom_range(3))
            0: num = $urandom;
            1: num = $urandom_range(0, 9999);
            2: begin
               p = 1;
               repeat ($urandom_range(9)) p *= 10;
               num = p * $urandom_range(0, 4);
            end
            default: num = $urandom >> $urandom_range(31);
         endcase
         if ($urandom_range(9) < 8) places = 4'($urandom_range(1, 10));
         else places = 4'($urandom);
         if ($urandom_range(9) < 8) font = FONT_HEIGHT_OK;
         else font = 8'($urandom);
         send_item(num, places, font, 10'($urandom), 10'($urandom), 16'($urandom));
      end
      calm = 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_blanking();
      test_no_output();
      test_backpressure();
      test_random();
      req_valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && expected_chars.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

>>> sim.f
sv/dff_pkg.sv
sv/dff_front.sv
sv/dff_queue.sv
sv/dff_back.sv
sv/decimal_field_formatter.sv
tb/tb.sv
